FILE: rtl/dfr_pkg.sv
// Shared types and constants for the XOR-checked frame deframer.
// No dependencies; dfr_core, dfr_out_reg and the top level import this package.
package dfr_pkg;

  // Deframer phase, one-hot
  typedef enum logic [4:0] {
    PH_HUNT_FIRST  = 5'b00001,
    PH_HUNT_SECOND = 5'b00010,
    PH_LENGTH      = 5'b00100,
    PH_PAYLOAD     = 5'b01000,
    PH_CHECK       = 5'b10000
  } phase_e;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_FATAL   = 2'd3
  } kind_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HDR_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HDR_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FAIL_LIMIT = 2'd2;

  localparam int unsigned CfgDataW = 8;

  // Reset values of the configuration registers
  localparam logic [7:0] HdrFirstRst  = 8'hAA;
  localparam logic [7:0] HdrSecondRst = 8'h55;
  localparam logic [3:0] FailLimitRst = 4'd3;

  // Added to the payload length to give the reported frame length
  localparam logic [8:0] FrameOverhead = 9'd3;

  typedef struct packed {
    logic [7:0] hdr_first;
    logic [7:0] hdr_second;
    logic [3:0] fail_limit;
  } cfg_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_pos;
    logic [8:0] frame_len;
  } result_t;

endpackage

FILE: rtl/dfr_channels.sv
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Plain logic widths; no package dependency.
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_position;
  logic [8:0] frame_length;

  modport source (output valid, output result_kind, output data_byte,
                  output byte_position, output frame_length, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input byte_position, input frame_length, output ready);
endinterface

FILE: rtl/dfr_core.sv
// Deframer state machine: header hunt, length, payload, XOR checksum check.
// Depends on dfr_pkg.
module dfr_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  dfr_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output dfr_pkg::result_t res_o
);
  import dfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] xor_q, xor_d;
  logic [3:0] fail_q, fail_d;
  logic [7:0] cnt_inc;

  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    xor_d       = xor_q;
    fail_d      = fail_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_PAYLOAD, data_byte: 8'd0, byte_pos: 8'd0, frame_len: 9'd0};
    if (step_i) begin
      unique case (phase_q)
        PH_HUNT_FIRST: begin
          held_d  = byte_i;
          phase_d = PH_HUNT_SECOND;
        end
        PH_HUNT_SECOND: begin
          if (held_q == cfg_i.hdr_first && byte_i == cfg_i.hdr_second) begin
            phase_d = PH_LENGTH;
          end else begin
            phase_d = PH_HUNT_FIRST;
          end
        end
        PH_LENGTH: begin
          len_d   = byte_i;
          xor_d   = byte_i;
          cnt_d   = 8'd0;
          phase_d = (byte_i == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_PAYLOAD;
          res_o.data_byte = byte_i;
          res_o.byte_pos  = cnt_q;
          xor_d           = xor_q ^ byte_i;
          cnt_d           = cnt_inc;
          if (cnt_inc == len_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res_valid_o = 1'b1;
          phase_d     = PH_HUNT_FIRST;
          if (byte_i == xor_q) begin
            fail_d          = 4'd0;
            res_o.kind      = KIND_GOOD;
            res_o.frame_len = {1'b0, len_q} + FrameOverhead;
          end else if (fail_q >= cfg_i.fail_limit) begin
            fail_d     = 4'd0;
            res_o.kind = KIND_FATAL;
          end else begin
            fail_d     = fail_q + 4'd1;
            res_o.kind = KIND_BAD;
          end
        end
        default: phase_d = PH_HUNT_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT_FIRST;
      held_q  <= 8'd0;
      len_q   <= 8'd0;
      cnt_q   <= 8'd0;
      xor_q   <= 8'd0;
      fail_q  <= 4'd0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      fail_q  <= fail_d;
    end
  end

  a_payload_always_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_PAYLOAD |-> res_valid_o && res_o.kind == KIND_PAYLOAD)
    else $error("payload byte gave no payload result");

  a_check_returns_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_CHECK |=> phase_q == PH_HUNT_FIRST)
    else $error("checksum byte did not restart the hunt");

  a_good_clears_failures: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KIND_GOOD || res_o.kind == KIND_FATAL) |=> fail_q == 4'd0)
    else $error("failure count not cleared after good or fatal report");

endmodule

FILE: rtl/dfr_out_reg.sv
// Result register driving the output channel; frees itself as the sink takes the item.
// Depends on dfr_pkg and dfr_out_if.
module dfr_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  dfr_pkg::result_t res_i,
  output logic             free_o,
  dfr_out_if.source        res_o
);
  import dfr_pkg::*;

  logic    valid_q;
  result_t res_q;

  // Slot is free when empty or when its item leaves this cycle
  assign free_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.result_kind   = res_q.kind;
  assign res_o.data_byte     = res_q.data_byte;
  assign res_o.byte_position = res_q.byte_pos;
  assign res_o.frame_length  = res_q.frame_len;

endmodule

FILE: rtl/xor_checked_frame_deframer_unit.sv
// Top level of the XOR-checked frame deframer; instantiates dfr_core and dfr_out_reg.
// Depends on dfr_pkg and the channel interfaces in dfr_channels.sv.
//
// The deframer takes one received byte per item on rx_i and hunts for a two-byte
// header in aligned pairs: a pair that is not header_first then header_second is
// dropped whole. After the header come a length byte, that many payload bytes
// (each given out on res_o as a payload item with its position), and one checksum
// byte equal to the XOR of the length and payload bytes. The checksum byte gives
// frame good (with length plus three), checksum bad, or fatal once the count of
// consecutive failures has reached failure_limit; good and fatal clear that count.
// Header, length and hunt bytes give no result. Throughput is one byte per clock
// while res_o is not stalled: each byte lands in an input register when it is
// accepted, then passes the state machine into a result register once that
// register is free, and its result is offered on res_o from there. A stalled result
// register holds the input register, and rx_i.ready follows res_o.ready in the same
// cycle. Configuration registers (index 0 header_first, 1 header_second,
// 2 failure_limit; other indexes are ignored) are written through cfg_we_i and
// should change only while no byte is in flight.
module xor_checked_frame_deframer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dfr_in_if.sink                       rx_i,
  dfr_out_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [dfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dfr_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import dfr_pkg::*;

  cfg_t       cfg_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       out_free;
  logic       s1_adv;
  logic       rx_fire;
  logic       res_valid;
  result_t    res;

  // Configuration registers; out-of-range indexes fall through untouched
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_first  <= HdrFirstRst;
      cfg_q.hdr_second <= HdrSecondRst;
      cfg_q.fail_limit <= FailLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HDR_FIRST:  cfg_q.hdr_first  <= cfg_wdata_i;
        CFG_HDR_SECOND: cfg_q.hdr_second <= cfg_wdata_i;
        CFG_FAIL_LIMIT: cfg_q.fail_limit <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Input stage: advance the held byte into the state machine whenever the
  // result register can take whatever it produces
  assign s1_adv     = s1_valid_q && out_free;
  assign rx_i.ready = !s1_valid_q || s1_adv;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  dfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_adv),
    .byte_i      (s1_byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dfr_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_adv && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

  a_stalled_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input stage lost or changed a stalled byte");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire |=> s1_valid_q)
    else $error("accepted byte did not reach the input stage");

  a_result_only_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> s1_adv)
    else $error("state machine produced a result without a byte");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for xor_checked_frame_deframer_unit: directed frames, then random traffic.
// Depends on dfr_pkg, the channel interfaces in rtl/dfr_channels.sv and the design under test.
// Results are checked item by item against an in-bench deframer predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dfr_pkg::*;

  // Index that maps to no register; writes to it must leave the block unchanged
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES    = 6;     // bytes with no result may still be in flight
  localparam int STALL_LIMIT     = 2000;  // cycles with no item moving on either side
  localparam int PHASES          = 12;
  localparam int BYTES_PER_PHASE = 130;
  localparam int MAX_REPORTS     = 40;

  // How the expectation of a directed row is formed
  typedef enum {CHK_PREDICT, CHK_NO_RESULT, CHK_TYPED} chk_e;
  typedef enum {ROW_BYTE, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e            op;
    logic [CfgIdxW-1:0] idx;   // register for ROW_CFG rows
    logic [7:0]         v;     // received byte or register data
    chk_e               chk;
    kind_e              kind;  // typed result, data_byte is v for payload items
    logic [7:0]         pos;
    logic [8:0]         len;
  } dir_row_t;

  logic               clk;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [7:0]         cfg_wdata;

  dfr_in_if  rx_if ();
  dfr_out_if res_if ();

  xor_checked_frame_deframer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .rx_i        (rx_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Register mirror and deframer state as the predictor sees them
  cfg_t       cfg_m = '{hdr_first: HdrFirstRst, hdr_second: HdrSecondRst,
                        fail_limit: FailLimitRst};
  phase_e     ph        = PH_HUNT_FIRST;
  logic [7:0] held_byte = 8'd0;
  logic [7:0] pay_len   = 8'd0;
  logic [7:0] pay_cnt   = 8'd0;
  logic [7:0] xor_acc   = 8'd0;
  logic [3:0] fail_cnt  = 4'd0;

  result_t    exp_q[$];          // results still owed by the block, oldest first
  chk_e       typed_mode = CHK_PREDICT;
  result_t    typed_res;
  bit         no_gaps    = 1'b0;
  int         bytes_sent  = 0;
  int         bytes_taken = 0;
  int         errors      = 0;
  int         idle_cycles = 0;
  int         kind_seen[4] = '{0, 0, 0, 0};
  int         reg_writes  = 0;

  // Directed part: defaults first, then limit zero, then a changed header.
  dir_row_t plan [30] = '{
    // zero-length frame right after reset: checksum equals the length byte
    '{ROW_BYTE, CFG_UNUSED, 8'hAA, CHK_NO_RESULT, KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h55, CHK_NO_RESULT, KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h00, CHK_NO_RESULT, KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h00, CHK_TYPED,     KIND_GOOD,    8'd0, 9'd3},
    // pair 00,AA is not a header: drop both, then a one-byte frame
    '{ROW_BYTE, CFG_UNUSED, 8'h00, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'hAA, CHK_NO_RESULT, KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'hAA, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h55, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h01, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'hFF, CHK_TYPED,     KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'hFE, CHK_TYPED,     KIND_GOOD,    8'd0, 9'd4},
    // wrong checksum: counted as a failure
    '{ROW_BYTE, CFG_UNUSED, 8'hAA, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h55, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h01, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h00, CHK_TYPED,     KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h00, CHK_TYPED,     KIND_BAD,     8'd0, 9'd0},
    // limit zero: the next failure is fatal at once
    '{ROW_CFG,  CFG_FAIL_LIMIT, 8'h00, CHK_PREDICT, KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'hAA, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h55, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h00, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'hFF, CHK_TYPED,     KIND_FATAL,   8'd0, 9'd0},
    // new header 00,FF; a write to the unused index changes nothing
    '{ROW_CFG,  CFG_HDR_FIRST,  8'h00, CHK_PREDICT, KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_CFG,  CFG_HDR_SECOND, 8'hFF, CHK_PREDICT, KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_CFG,  CFG_UNUSED,     8'h12, CHK_PREDICT, KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'hAA, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h55, CHK_NO_RESULT, KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h00, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'hFF, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h00, CHK_PREDICT,   KIND_PAYLOAD, 8'd0, 9'd0},
    '{ROW_BYTE, CFG_UNUSED, 8'h00, CHK_TYPED,     KIND_GOOD,    8'd0, 9'd3}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the deframer by one received byte; has is set when a result is due.
  function automatic void deframe_byte(input logic [7:0] b, output bit has,
                                       output result_t r);
    r   = '0;
    has = 1'b0;
    case (ph)
      PH_HUNT_FIRST: begin
        held_byte = b;
        ph = PH_HUNT_SECOND;
      end
      PH_HUNT_SECOND: begin
        // aligned pair: a mismatch drops both bytes
        ph = (held_byte == cfg_m.hdr_first && b == cfg_m.hdr_second) ? PH_LENGTH
                                                                      : PH_HUNT_FIRST;
      end
      PH_LENGTH: begin
        pay_len = b;
        xor_acc = b;
        pay_cnt = 8'd0;
        ph = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        has         = 1'b1;
        r.kind      = KIND_PAYLOAD;
        r.data_byte = b;
        r.byte_pos  = pay_cnt;
        xor_acc     = xor_acc ^ b;
        pay_cnt     = pay_cnt + 8'd1;
        if (pay_cnt == pay_len) ph = PH_CHECK;
      end
      PH_CHECK: begin
        has = 1'b1;
        ph  = PH_HUNT_FIRST;
        if (b == xor_acc) begin
          fail_cnt    = 4'd0;
          r.kind      = KIND_GOOD;
          r.frame_len = {1'b0, pay_len} + FrameOverhead;
        end else if (fail_cnt >= cfg_m.fail_limit) begin
          // also taken when the limit was lowered below the running count
          fail_cnt = 4'd0;
          r.kind   = KIND_FATAL;
        end else begin
          fail_cnt = fail_cnt + 4'd1;
          r.kind   = KIND_BAD;
        end
      end
      default: ph = PH_HUNT_FIRST;
    endcase
  endfunction

  task automatic compare_field(input string what, input logic [8:0] want,
                               input logic [8:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Monitor: check results, predict from accepted bytes, and watch for a hang.
  always @(posedge clk) begin : monitor
    result_t want;
    result_t pred;
    bit      has;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      // check before predicting: a result never belongs to the byte taken at this edge
      if (res_if.valid && res_if.ready) begin
        moved = 1'b1;
        if (exp_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result kind %0d arrived with nothing expected",
                     $time, res_if.result_kind);
        end else begin
          want = exp_q.pop_front();
          compare_field("result_kind", 9'(want.kind), 9'(res_if.result_kind));
          compare_field("data_byte", 9'(want.data_byte), 9'(res_if.data_byte));
          compare_field("byte_position", 9'(want.byte_pos), 9'(res_if.byte_position));
          compare_field("frame_length", want.frame_len, res_if.frame_length);
          kind_seen[want.kind]++;
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        moved = 1'b1;
        deframe_byte(rx_if.rx_byte, has, pred);
        // a typed row overrides the predictor's view of what is owed
        if (typed_mode == CHK_TYPED) exp_q.push_back(typed_res);
        else if (typed_mode == CHK_PREDICT && has) exp_q.push_back(pred);
        bytes_taken++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: nothing moved for %0d cycles, %0d results owed",
                 $time, idle_cycles, exp_q.size());
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // Result side: hold ready for a while, then stall; most stalls short, a few long.
  task automatic hold_ready(input logic val, input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      res_if.ready <= val;
    end
  endtask

  initial begin : result_sink
    int r;
    res_if.ready = 1'b0;
    forever begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        hold_ready(1'b1, $urandom_range(10, 60));
      end else begin
        hold_ready(1'b0, (r == 9) ? $urandom_range(15, 40) : $urandom_range(1, 3));
        hold_ready(1'b1, $urandom_range(1, 4));
      end
    end
  end

  // Offer one byte after a random gap, and return once it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      @(negedge clk);
      rx_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    bytes_sent++;
    wait (bytes_taken == bytes_sent);
  endtask

  // Hold off the sender until every owed result is out, then let stray bytes drain.
  task automatic settle();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HDR_FIRST:  cfg_m.hdr_first  = val;
      CFG_HDR_SECOND: cfg_m.hdr_second = val;
      CFG_FAIL_LIMIT: cfg_m.fail_limit = val[3:0];
      default: ;  // unused index: ignored by the block
    endcase
    reg_writes++;
  endtask

  // Send a frame under the current header. n_pay below len or no checksum
  // leaves it truncated; the next frame then flushes it out.
  task automatic send_frame(input logic [7:0] len, input int n_pay,
                            input bit corrupt, input bit with_check);
    logic [7:0] x;
    logic [7:0] b;
    while (ph != PH_HUNT_FIRST && ph != PH_HUNT_SECOND) send_byte(8'($urandom_range(0, 255)));
    // realign most of the time; otherwise let the header straddle a pair
    if (ph == PH_HUNT_SECOND && $urandom_range(0, 9) != 0) send_byte(8'($urandom_range(0, 255)));
    send_byte(cfg_m.hdr_first);
    send_byte(cfg_m.hdr_second);
    send_byte(len);
    x = len;
    for (int i = 0; i < n_pay; i++) begin
      b = 8'($urandom_range(0, 255));
      x = x ^ b;
      send_byte(b);
    end
    if (with_check) send_byte(corrupt ? x ^ 8'($urandom_range(1, 255)) : x);
  endtask

  initial begin : stimulus
    dir_row_t   row;
    logic [7:0] hf;
    logic [7:0] hs;
    logic [3:0] lim;
    logic [7:0] len;
    int         bad_pct;
    int         start;
    int         r;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'd0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_HDR_FIRST;
    cfg_wdata     = 8'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed rows: typed rows carry their own expectation, the rest are predicted.
    foreach (plan[i]) begin
      row = plan[i];
      if (row.op == ROW_CFG) begin
        write_reg(row.idx, row.v);
      end else begin
        typed_res           = '0;
        typed_res.kind      = row.kind;
        typed_res.data_byte = (row.kind == KIND_PAYLOAD) ? row.v : 8'd0;
        typed_res.byte_pos  = row.pos;
        typed_res.frame_len = row.len;
        typed_mode          = row.chk;
        send_byte(row.v);
        typed_mode = CHK_PREDICT;
      end
    end

    // Random phases, each under its own register setting, extremes first.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin  // mostly failures under the top limit to build up the count
          hf = HdrFirstRst; hs = HdrSecondRst; lim = 4'd15; bad_pct = 80;
        end
        1: begin  // drop the limit below whatever count phase 0 left behind
          hf = HdrFirstRst; hs = HdrSecondRst; lim = 4'd1; bad_pct = 60;
        end
        2: begin
          hf = 8'hFF; hs = 8'h00; lim = 4'd0; bad_pct = 30;
        end
        3: begin
          hf = 8'h00; hs = 8'hFF; lim = 4'd15; bad_pct = 40;
        end
        4: begin  // both header bytes equal
          hf = 8'($urandom_range(0, 255)); hs = hf;
          lim = 4'($urandom_range(0, 15)); bad_pct = 30;
        end
        default: begin
          hf = 8'($urandom_range(0, 255)); hs = 8'($urandom_range(0, 255));
          lim = 4'($urandom_range(0, 15)); bad_pct = $urandom_range(5, 50);
        end
      endcase
      write_reg(CFG_HDR_FIRST, hf);
      write_reg(CFG_HDR_SECOND, hs);
      // upper data bits are noise: only the low nibble reaches the limit
      write_reg(CFG_FAIL_LIMIT, {4'($urandom_range(0, 15)), lim});
      if ($urandom_range(0, 1) == 1) write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));

      // longest frame once: positions up to 254, frame length 258
      if (p == 2) send_frame(8'd255, 255, 1'b0, 1'b1);

      start = bytes_sent;
      while (bytes_sent - start < BYTES_PER_PHASE) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 85) begin
          r = $urandom_range(0, 99);
          if (r < 10) len = 8'd0;
          else if (r < 93) len = 8'($urandom_range(1, 12));
          else if (r < 98) len = 8'($urandom_range(13, 64));
          else len = 8'($urandom_range(65, 255));
          send_frame(len, len, ($urandom_range(0, 99) < bad_pct), 1'b1);
        end else if (r < 92) begin
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        end else if (r < 96) begin
          // first header byte right, second wrong
          send_byte(cfg_m.hdr_first);
          send_byte(cfg_m.hdr_second ^ 8'($urandom_range(1, 255)));
        end else begin
          len = 8'($urandom_range(4, 20));
          send_frame(len, $urandom_range(0, len - 1), 1'b0, 1'b0);
        end
      end
    end
    no_gaps = 1'b0;

    settle();
    $display("%0d bytes in; results: %0d payload, %0d good, %0d bad, %0d fatal",
             bytes_taken, kind_seen[KIND_PAYLOAD], kind_seen[KIND_GOOD],
             kind_seen[KIND_BAD], kind_seen[KIND_FATAL]);
    $display("%0d register writes over %0d settings, incl. header extremes and limits 0/15",
             reg_writes, PHASES + 2);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: xor_checked_frame_deframer_unit.f
rtl/dfr_pkg.sv
rtl/dfr_channels.sv
rtl/dfr_core.sv
rtl/dfr_out_reg.sv
rtl/xor_checked_frame_deframer_unit.sv
tb/tb_top.sv
